// File: rtl/fcht_pkg.sv
// Shared constants and types for the forward cone hit test.
// Used by the prep stage, the CORDIC cells and the judge stage; no dependencies.
`timescale 1ns / 1ps

package fcht_pkg;

	// Offsets are scaled by 2^GUARD_SHIFT before rotation.
	localparam int GUARD_SHIFT = 24;
	// Depth of the arctangent table; deeper chains are clipped to it.
	localparam int TABLE_SIZE  = 24;
	// Angle accumulator resolution, units of 2^-32 turn.
	localparam int TURN_BITS   = 32;

	typedef logic [TURN_BITS-1:0] turn_t;

	localparam turn_t HALF_TURN = turn_t'(32'h8000_0000);

	// round(atan(2^-i) * 2^32 / (2*pi))
	localparam turn_t ATAN_TURNS [TABLE_SIZE] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

endpackage

// File: rtl/fcht_if.sv
// Valid/ready channel interfaces for the query and the result beats.
// Standalone; widths follow the block parameters.
`timescale 1ns / 1ps

interface fcht_req_if #(
	parameter int POS_BITS   = 16,
	parameter int ANGLE_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [POS_BITS-1:0]   viewer_x;
	logic signed [POS_BITS-1:0]   viewer_z;
	logic        [ANGLE_BITS-1:0] viewer_heading;
	logic signed [POS_BITS-1:0]   target_x;
	logic signed [POS_BITS-1:0]   target_z;
	logic        [POS_BITS-1:0]   reach;
	logic        [ANGLE_BITS-1:0] half_width;

	modport source (
		output valid, viewer_x, viewer_z, viewer_heading, target_x, target_z,
		       reach, half_width,
		input  ready
	);
	modport sink (
		input  valid, viewer_x, viewer_z, viewer_heading, target_x, target_z,
		       reach, half_width,
		output ready
	);
endinterface

interface fcht_rsp_if ();
	logic valid;
	logic ready;
	logic hit;
	logic within_reach;

	modport source (output valid, hit, within_reach, input ready);
	modport sink   (input valid, hit, within_reach, output ready);
endinterface

// File: rtl/fcht_prep.sv
// Front end: offsets, squared distance and reach, CORDIC pre-rotation.
// Depends on fcht_pkg and fcht_req_if.
`timescale 1ns / 1ps

module fcht_prep #(
	parameter int POS_BITS   = 16,
	parameter int ANGLE_BITS = 16,
	parameter int XW         = 44,
	parameter int SQW        = 34
) (
	input  logic                         clk,
	input  logic                         arst_n,
	fcht_req_if.sink                     req,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output logic signed [XW-1:0]         x_out,
	output logic signed [XW-1:0]         y_out,
	output fcht_pkg::turn_t              ang_out,
	output logic                         zero_out,
	output logic [ANGLE_BITS-1:0]        heading_out,
	output logic [ANGLE_BITS-1:0]        tol_out,
	output logic [SQW-1:0]               sx_out,
	output logic [SQW-1:0]               sz_out,
	output logic [2*POS_BITS-1:0]        r2_out
);
	import fcht_pkg::*;

	localparam int DW  = POS_BITS + 1;
	localparam int EXT = XW - DW - GUARD_SHIFT;

	logic                  v_s1, v_s2;
	logic                  rdy_s1, rdy_s2;
	logic signed [DW-1:0]  dx_s1, dz_s1;
	logic [ANGLE_BITS-1:0] heading_s1, tol_s1;
	logic [POS_BITS-1:0]   reach_s1;

	logic [DW-1:0]         ax, az;
	logic [2*DW-1:0]       px, pz;
	logic signed [XW-1:0]  xs, ys;

	logic signed [XW-1:0]  x_s2, y_s2;
	turn_t                 ang_s2;
	logic                  zero_s2;
	logic [ANGLE_BITS-1:0] heading_s2, tol_s2;
	logic [SQW-1:0]        sx_s2, sz_s2;
	logic [2*POS_BITS-1:0] r2_s2;

	assign rdy_s2    = !v_s2 || dn_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req.valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req.valid) begin
			dx_s1      <= DW'(req.target_x) - DW'(req.viewer_x);
			dz_s1      <= DW'(req.target_z) - DW'(req.viewer_z);
			heading_s1 <= req.viewer_heading;
			tol_s1     <= req.half_width;
			reach_s1   <= req.reach;
		end
	end

	always_comb begin
		ax = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		az = dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);
		px = (2*DW)'(ax) * (2*DW)'(ax);
		pz = (2*DW)'(az) * (2*DW)'(az);
		xs = {{EXT{dz_s1[DW-1]}}, dz_s1, {GUARD_SHIFT{1'b0}}};
		ys = {{EXT{dx_s1[DW-1]}}, dx_s1, {GUARD_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			sx_s2      <= px[SQW-1:0];
			sz_s2      <= pz[SQW-1:0];
			r2_s2      <= (2*POS_BITS)'(reach_s1) * (2*POS_BITS)'(reach_s1);
			zero_s2    <= (dx_s1 == '0) && (dz_s1 == '0);
			heading_s2 <= heading_s1;
			tol_s2     <= tol_s1;
			// Fold the left half plane onto the right one.
			if (dz_s1[DW-1]) begin
				x_s2   <= -xs;
				y_s2   <= -ys;
				ang_s2 <= HALF_TURN;
			end else begin
				x_s2   <= xs;
				y_s2   <= ys;
				ang_s2 <= '0;
			end
		end
	end

	assign dn_valid    = v_s2;
	assign x_out       = x_s2;
	assign y_out       = y_s2;
	assign ang_out     = ang_s2;
	assign zero_out    = zero_s2;
	assign heading_out = heading_s2;
	assign tol_out     = tol_s2;
	assign sx_out      = sx_s2;
	assign sz_out      = sz_s2;
	assign r2_out      = r2_s2;

endmodule

// File: rtl/fcht_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its own pipeline register and handshake.
// Depends on fcht_pkg for the arctangent table.
`timescale 1ns / 1ps

module fcht_cordic_cell #(
	parameter int XW    = 44,
	parameter int SB_W  = 34,
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  fcht_pkg::turn_t      ang_in,
	input  logic [SB_W-1:0]      sb_in,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output fcht_pkg::turn_t      ang_out,
	output logic [SB_W-1:0]      sb_out
);
	import fcht_pkg::*;

	logic                 v_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	turn_t                ang_s1;
	logic [SB_W-1:0]      sb_s1;
	logic signed [XW-1:0] xsh, ysh;

	assign up_ready = !v_s1 || dn_ready;
	assign xsh      = x_in >>> STAGE;
	assign ysh      = y_in >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			sb_s1 <= sb_in;
			// Rotate toward the x axis, steering by the sign of y.
			if (!y_in[XW-1]) begin
				x_s1   <= x_in + ysh;
				y_s1   <= y_in - xsh;
				ang_s1 <= ang_in + ATAN_TURNS[STAGE];
			end else begin
				x_s1   <= x_in - ysh;
				y_s1   <= y_in + xsh;
				ang_s1 <= ang_in - ATAN_TURNS[STAGE];
			end
		end
	end

	assign dn_valid = v_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign ang_out  = ang_s1;
	assign sb_out   = sb_s1;

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !dn_ready |=> v_s1 && $stable(ang_s1) && $stable(sb_s1))
		else $error("cell lost or changed a stalled beat");
	a_busy_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> v_s1)
		else $error("cell refused a beat while empty");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_ready |=> v_s1)
		else $error("cell dropped an accepted beat");
`endif

endmodule

// File: rtl/fcht_judge.sv
// Final stage: round the bearing, wrap against heading, compare, register the result.
// Depends on fcht_pkg and fcht_rsp_if.
`timescale 1ns / 1ps

module fcht_judge #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  fcht_pkg::turn_t       ang_in,
	input  logic                  zero_in,
	input  logic                  within_in,
	input  logic [ANGLE_BITS-1:0] heading_in,
	input  logic [ANGLE_BITS-1:0] tol_in,
	fcht_rsp_if.source            rsp
);
	import fcht_pkg::*;

	localparam int DROP = TURN_BITS - ANGLE_BITS;

	logic                  v_s1, hit_s1, within_s1;
	turn_t                 rnd;
	logic [ANGLE_BITS-1:0] bearing, diff, mag;
	logic                  in_angle;

	always_comb begin
		rnd      = ang_in + (turn_t'(1) << (DROP - 1));
		// A zero offset has no direction; take bearing zero.
		bearing  = zero_in ? '0 : rnd[TURN_BITS-1:DROP];
		diff     = bearing - heading_in;
		mag      = diff[ANGLE_BITS-1] ? ANGLE_BITS'(-diff) : diff;
		in_angle = mag < tol_in;
	end

	assign up_ready = !v_s1 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			hit_s1    <= within_in && in_angle;
			within_s1 <= within_in;
		end
	end

	assign rsp.valid        = v_s1;
	assign rsp.hit          = hit_s1;
	assign rsp.within_reach = within_s1;

`ifndef NO_ASSERTIONS
	a_hit_needs_reach: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> rsp.within_reach)
		else $error("hit reported outside reach");
`endif

endmodule

// File: rtl/forward_cone_hit_test_top.sv
// Forward cone hit test: a pipeline of two front-end stages, one register per CORDIC
// cell (CORDIC_STAGES cells, clipped at 24), and the judge stage.
// Throughput is one query per cycle while rsp is ready; each stage has its own valid
// flag and holds under backpressure, so bubbles close up. Reset clears only the valid flags.
// Depends on fcht_pkg, fcht_if, fcht_prep, fcht_cordic_cell and fcht_judge.
`timescale 1ns / 1ps

module forward_cone_hit_test_top #(
	parameter int POS_BITS      = 16,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	fcht_req_if.sink   req,
	fcht_rsp_if.source rsp
);
	import fcht_pkg::*;

	localparam int NSTG = (CORDIC_STAGES > TABLE_SIZE) ? TABLE_SIZE : CORDIC_STAGES;
	localparam int XW   = POS_BITS + 4 + GUARD_SHIFT;
	localparam int SQW  = (2*POS_BITS + 2 > 64) ? 64 : 2*POS_BITS + 2;
	localparam int SB_W = 2*ANGLE_BITS + 2;

	logic signed [XW-1:0]  cx  [NSTG+1];
	logic signed [XW-1:0]  cy  [NSTG+1];
	turn_t                 ca  [NSTG+1];
	logic [SB_W-1:0]       csb [NSTG+1];
	logic                  cv  [NSTG+1];
	logic                  cr  [NSTG+1];

	logic                  zero;
	logic [ANGLE_BITS-1:0] heading, tol;
	logic [SQW-1:0]        sx, sz;
	logic [2*POS_BITS-1:0] r2;
	logic [SQW:0]          dist2;
	logic                  in_reach;

	fcht_prep #(
		.POS_BITS  (POS_BITS),
		.ANGLE_BITS(ANGLE_BITS),
		.XW        (XW),
		.SQW       (SQW)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.dn_valid   (cv[0]),
		.dn_ready   (cr[0]),
		.x_out      (cx[0]),
		.y_out      (cy[0]),
		.ang_out    (ca[0]),
		.zero_out   (zero),
		.heading_out(heading),
		.tol_out    (tol),
		.sx_out     (sx),
		.sz_out     (sz),
		.r2_out     (r2)
	);

	// The carry out of the square sum keeps an overflowed distance out of reach.
	assign dist2    = {1'b0, sx} + {1'b0, sz};
	assign in_reach = dist2 <= (SQW+1)'(r2);
	assign csb[0]   = {heading, tol, in_reach, zero};

	for (genvar k = 0; k < NSTG; k++) begin : g_cell
		fcht_cordic_cell #(
			.XW   (XW),
			.SB_W (SB_W),
			.STAGE(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(cv[k]),
			.up_ready(cr[k]),
			.x_in    (cx[k]),
			.y_in    (cy[k]),
			.ang_in  (ca[k]),
			.sb_in   (csb[k]),
			.dn_valid(cv[k+1]),
			.dn_ready(cr[k+1]),
			.x_out   (cx[k+1]),
			.y_out   (cy[k+1]),
			.ang_out (ca[k+1]),
			.sb_out  (csb[k+1])
		);
	end

	fcht_judge #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (cv[NSTG]),
		.up_ready  (cr[NSTG]),
		.ang_in    (ca[NSTG]),
		.zero_in   (csb[NSTG][0]),
		.within_in (csb[NSTG][1]),
		.heading_in(csb[NSTG][SB_W-1 -: ANGLE_BITS]),
		.tol_in    (csb[NSTG][ANGLE_BITS+1 -: ANGLE_BITS]),
		.rsp       (rsp)
	);

endmodule
